/* rtl/rrca_pkg.sv */
package rrca_pkg;

   localparam int MAX_DIM    = 2048;
   localparam int DIM_W      = 12;
   localparam int COORD_W    = 11;
   localparam int ADDR_W     = 22;
   localparam int CMD_W      = 2;
   localparam int STATUS_W   = 2;
   localparam int ROT_W      = 2;
   localparam int REG_IDX_W  = 3;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 96;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

   localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SNAP   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_STEP   = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ROTATION = 2'd2;

   localparam logic [ROT_W-1:0] ROT_NONE = 2'd0;
   localparam logic [ROT_W-1:0] ROT_90   = 2'd1;
   localparam logic [ROT_W-1:0] ROT_180  = 2'd2;
   localparam logic [ROT_W-1:0] ROT_270  = 2'd3;

   localparam logic [REG_IDX_W-1:0] REG_ROTATION      = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_BITMAP_WIDTH  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_BITMAP_HEIGHT = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd4;

   localparam logic KIND_ANSWER = 1'b0;
   localparam logic KIND_PAIR   = 1'b1;

   typedef struct packed {
      logic [ROT_W-1:0] rotation;
      logic [DIM_W-1:0] bitmap_width;
      logic [DIM_W-1:0] bitmap_height;
      logic [DIM_W-1:0] screen_width;
      logic [DIM_W-1:0] screen_height;
   } cfg_type;

   // one queue slot: either a finished start or a step token
   typedef struct packed {
      logic                is_start;
      logic [STATUS_W-1:0] status;
      logic [DIM_W-1:0]    run_w;
      logic [DIM_W-1:0]    run_h;
      logic [COORD_W-1:0]  region_x;
      logic [COORD_W-1:0]  region_y;
      logic [DIM_W-1:0]    region_w;
      logic [DIM_W-1:0]    region_h;
      logic [ADDR_W-1:0]   src_origin;
      logic [ADDR_W-1:0]   dst_origin;
      logic [ADDR_W-1:0]   src_row_step;
      logic [ADDR_W-1:0]   src_col_step;
      logic [ADDR_W-1:0]   dst_row_step;
      logic [ADDR_W-1:0]   dst_col_step;
   } entry_type;

endpackage

/* rtl/rrca_fifo.sv */
module rrca_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rrca_pkg::entry_type push_entry,
   input  logic                pop,
   output rrca_pkg::entry_type head,
   output logic                empty,
   output logic                full
);

   rrca_pkg::entry_type                mem_ff [rrca_pkg::FIFO_DEPTH];
   logic [rrca_pkg::FIFO_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [rrca_pkg::FIFO_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [rrca_pkg::FIFO_PTR_W:0]      count_ff, count_in;

   localparam logic [rrca_pkg::FIFO_PTR_W-1:0] PTR_LAST =
      rrca_pkg::FIFO_PTR_W'(rrca_pkg::FIFO_DEPTH - 1);
   localparam logic [rrca_pkg::FIFO_PTR_W:0] COUNT_FULL =
      (rrca_pkg::FIFO_PTR_W + 1)'(rrca_pkg::FIFO_DEPTH);

   assign empty = (count_ff == '0);
   assign full  = (count_ff == COUNT_FULL);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* rtl/rrca_front.sv */
module rrca_front (
   input  logic                                clock,
   input  logic                                reset,
   input  rrca_pkg::cfg_type                   cfg,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rrca_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [rrca_pkg::CMD_W-1:0]          req_tuser,
   input  logic                                fifo_full,
   output logic                                push,
   output rrca_pkg::entry_type                 push_entry
);

   localparam int DW = rrca_pkg::DIM_W;
   localparam int AW = rrca_pkg::ADDR_W;
   localparam int CW = rrca_pkg::COORD_W;
   localparam logic [DW-1:0] DIM_ONE     = DW'(1);
   localparam logic [AW-1:0] ADDR_ONE    = AW'(1);
   localparam logic [AW-1:0] ADDR_NEG_ONE = '1;

   typedef struct packed {
      logic                          is_start;
      logic [rrca_pkg::STATUS_W-1:0] status;
      logic [DW-1:0]                 run_w;
      logic [DW-1:0]                 run_h;
      logic [CW-1:0]                 region_x;
      logic [CW-1:0]                 region_y;
      logic [DW-1:0]                 region_w;
      logic [DW-1:0]                 region_h;
      logic [DW-1:0]                 sa_a;
      logic [DW-1:0]                 sa_b;
      logic [DW-1:0]                 sa_c;
      logic [DW-1:0]                 da_a;
      logic [DW-1:0]                 da_b;
      logic [DW-1:0]                 da_c;
      logic [AW-1:0]                 src_row_step;
      logic [AW-1:0]                 src_col_step;
      logic [AW-1:0]                 dst_row_step;
      logic [AW-1:0]                 dst_col_step;
   } clip_type;

   function automatic logic [DW-1:0] dim_sat(input logic [DW-1:0] v);
      dim_sat = (v > DW'(rrca_pkg::MAX_DIM)) ? DW'(rrca_pkg::MAX_DIM) : v;
   endfunction

   function automatic logic [DW-1:0] min3(input logic [DW-1:0] a, input logic [DW-1:0] b,
                                          input logic [DW-1:0] c);
      logic [DW-1:0] m;
      m = (a < b) ? a : b;
      min3 = (m < c) ? m : c;
   endfunction

   // stage 0: captured transaction
   logic                         s0_valid_ff, s0_valid_in;
   logic [rrca_pkg::CMD_W-1:0]   s0_cmd_ff;
   logic [CW-1:0]                s0_rx_ff, s0_ry_ff, s0_dx_ff, s0_dy_ff;
   logic [DW-1:0]                s0_rw_ff, s0_rh_ff;
   // stage 1: clip result, multiply operands
   logic                         s1_valid_ff, s1_valid_in;
   clip_type                     s1_ff, clip;

   logic s0_ready, s1_ready, take;

   logic [DW-1:0] bw, bh, sw, sh, rx12, ry12, dx12, dy12;
   logic [DW-1:0] up180_xo, up180_yo, up180_w, up180_h, up90_w, up90_h;
   logic [DW-1:0] sn180_w, sn180_h, sn90_w, sn90_h;
   logic [AW-1:0] neg_sw;
   logic [2*DW-1:0] sa_prod, da_prod;

   assign s1_ready   = !s1_valid_ff || !fifo_full;
   assign s0_ready   = !s0_valid_ff || s1_ready;
   assign req_tready = s0_ready;
   assign take       = req_tvalid && s0_ready;
   assign push       = s1_valid_ff && !fifo_full;

   // code 3 is accepted and dropped here
   assign s0_valid_in = s0_ready ? (take && (req_tuser == rrca_pkg::CMD_UPDATE ||
                                             req_tuser == rrca_pkg::CMD_SNAP ||
                                             req_tuser == rrca_pkg::CMD_STEP))
                                 : s0_valid_ff;
   assign s1_valid_in = s1_ready ? s0_valid_ff : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s0_cmd_ff <= req_tuser;
         s0_rx_ff  <= req_tdata[10:0];
         s0_ry_ff  <= req_tdata[21:11];
         s0_rw_ff  <= req_tdata[33:22];
         s0_rh_ff  <= req_tdata[45:34];
         s0_dx_ff  <= req_tdata[56:46];
         s0_dy_ff  <= req_tdata[67:57];
      end
      if (s0_valid_ff && s1_ready) begin
         s1_ff <= clip;
      end
   end

   assign bw   = dim_sat(cfg.bitmap_width);
   assign bh   = dim_sat(cfg.bitmap_height);
   assign sw   = dim_sat(cfg.screen_width);
   assign sh   = dim_sat(cfg.screen_height);
   assign rx12 = DW'(s0_rx_ff);
   assign ry12 = DW'(s0_ry_ff);
   assign dx12 = DW'(s0_dx_ff);
   assign dy12 = DW'(s0_dy_ff);
   assign neg_sw = AW'(0) - AW'(sw);

   // candidates; the subtractions only matter on paths that passed the range checks
   assign up180_xo = sw - dx12;
   assign up180_yo = sh - dy12;
   assign up180_w  = min3(s0_rw_ff, up180_xo, bw - rx12);
   assign up180_h  = min3(s0_rh_ff, up180_yo, bh - ry12);
   assign up90_w   = min3(s0_rw_ff, bw - rx12, sh - dx12);
   assign up90_h   = min3(s0_rh_ff, bh - ry12, sw - dy12);
   assign sn180_w  = min3(s0_rw_ff, bw, sw - rx12);
   assign sn180_h  = min3(s0_rh_ff, bh, sh - ry12);
   assign sn90_w   = min3(s0_rw_ff, bw, sh - rx12);
   assign sn90_h   = min3(s0_rh_ff, bh, sw - ry12);

   always_comb begin
      clip = '0;
      clip.is_start = (s0_cmd_ff != rrca_pkg::CMD_STEP);
      if (clip.is_start) begin
         if (cfg.rotation != rrca_pkg::ROT_90 && cfg.rotation != rrca_pkg::ROT_180) begin
            clip.status = rrca_pkg::STATUS_ROTATION;
         end else if (s0_cmd_ff == rrca_pkg::CMD_UPDATE) begin
            if (rx12 >= bw || ry12 >= bh) begin
               clip.status = rrca_pkg::STATUS_RANGE;
            end else if (cfg.rotation == rrca_pkg::ROT_180) begin
               if (dx12 >= sw || dy12 >= sh) begin
                  clip.status = rrca_pkg::STATUS_RANGE;
               end else begin
                  clip.run_w        = up180_w;
                  clip.run_h        = up180_h;
                  clip.region_x     = CW'(up180_xo - up180_w);
                  clip.region_y     = CW'(up180_yo - up180_h);
                  clip.region_w     = up180_w;
                  clip.region_h     = up180_h;
                  clip.sa_a         = ry12;
                  clip.sa_b         = bw;
                  clip.sa_c         = rx12;
                  clip.da_a         = up180_yo - DIM_ONE;
                  clip.da_b         = sw;
                  clip.da_c         = up180_xo - DIM_ONE;
                  clip.src_row_step = AW'(bw);
                  clip.src_col_step = ADDR_ONE;
                  clip.dst_row_step = neg_sw;
                  clip.dst_col_step = ADDR_NEG_ONE;
               end
            end else begin
               if (dx12 >= sh || dy12 >= sw) begin
                  clip.status = rrca_pkg::STATUS_RANGE;
               end else begin
                  // screen column runs down the bitmap rows
                  clip.run_w        = up90_w;
                  clip.run_h        = up90_h;
                  clip.region_x     = CW'(sw - up90_h - dy12);
                  clip.region_y     = s0_dx_ff;
                  clip.region_w     = up90_h;
                  clip.region_h     = up90_w;
                  clip.sa_a         = ry12;
                  clip.sa_b         = bw;
                  clip.sa_c         = rx12;
                  clip.da_a         = dx12;
                  clip.da_b         = sw;
                  clip.da_c         = sw - DIM_ONE - dy12;
                  clip.src_row_step = AW'(bw);
                  clip.src_col_step = ADDR_ONE;
                  clip.dst_row_step = ADDR_NEG_ONE;
                  clip.dst_col_step = AW'(sw);
               end
            end
         end else begin
            if (cfg.rotation == rrca_pkg::ROT_180) begin
               if (rx12 >= sw || ry12 >= sh) begin
                  clip.status = rrca_pkg::STATUS_RANGE;
               end else begin
                  clip.run_w    = sn180_w;
                  clip.run_h    = sn180_h;
                  clip.region_x = CW'(sw - rx12 - sn180_w);
                  clip.region_y = CW'(sh - ry12 - sn180_h);
                  clip.region_w = sn180_w;
                  clip.region_h = sn180_h;
                  if (sn180_w != '0 && sn180_h != '0) begin
                     clip.sa_a = sn180_h - DIM_ONE;
                     clip.sa_b = sw;
                     clip.sa_c = sn180_w - DIM_ONE;
                  end
                  clip.src_row_step = neg_sw;
                  clip.src_col_step = ADDR_NEG_ONE;
                  clip.dst_row_step = AW'(bw);
                  clip.dst_col_step = ADDR_ONE;
               end
            end else begin
               if (rx12 >= sh || ry12 >= sw) begin
                  clip.status = rrca_pkg::STATUS_RANGE;
               end else begin
                  clip.run_w    = sn90_w;
                  clip.run_h    = sn90_h;
                  clip.region_x = CW'(sw - ry12 - sn90_h);
                  clip.region_y = s0_rx_ff;
                  clip.region_w = sn90_h;
                  clip.region_h = sn90_w;
                  clip.sa_c     = (sn90_h != '0) ? sn90_h - DIM_ONE : '0;
                  clip.src_row_step = ADDR_NEG_ONE;
                  clip.src_col_step = AW'(sw);
                  clip.dst_row_step = AW'(bw);
                  clip.dst_col_step = ADDR_ONE;
               end
            end
         end
      end
   end

   // origin = a * b + c, one multiplier per side, written straight into the queue
   assign sa_prod = s1_ff.sa_a * s1_ff.sa_b;
   assign da_prod = s1_ff.da_a * s1_ff.da_b;

   always_comb begin
      push_entry              = '0;
      push_entry.is_start     = s1_ff.is_start;
      push_entry.status       = s1_ff.status;
      push_entry.run_w        = s1_ff.run_w;
      push_entry.run_h        = s1_ff.run_h;
      push_entry.region_x     = s1_ff.region_x;
      push_entry.region_y     = s1_ff.region_y;
      push_entry.region_w     = s1_ff.region_w;
      push_entry.region_h     = s1_ff.region_h;
      push_entry.src_origin   = sa_prod[AW-1:0] + AW'(s1_ff.sa_c);
      push_entry.dst_origin   = da_prod[AW-1:0] + AW'(s1_ff.da_c);
      push_entry.src_row_step = s1_ff.src_row_step;
      push_entry.src_col_step = s1_ff.src_col_step;
      push_entry.dst_row_step = s1_ff.dst_row_step;
      push_entry.dst_col_step = s1_ff.dst_col_step;
   end

endmodule

/* rtl/rrca_back.sv */
module rrca_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                fifo_empty,
   input  rrca_pkg::entry_type                 head,
   output logic                                pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // status, src_addr, dst_addr, region_x, region_y, region_w, region_h, zero fill
   output logic [rrca_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // kind
   output logic [0:0]                          rsp_tuser,
   output logic                                rsp_tlast
);

   localparam int DW = rrca_pkg::DIM_W;
   localparam int AW = rrca_pkg::ADDR_W;
   localparam int CW = rrca_pkg::COORD_W;

   typedef struct packed {
      logic [DW-1:0] run_w;
      logic [DW-1:0] run_h;
      logic [DW-1:0] row;
      logic [DW-1:0] col;
      logic [AW-1:0] src_cur;
      logic [AW-1:0] src_base;
      logic [AW-1:0] dst_cur;
      logic [AW-1:0] dst_base;
      logic [AW-1:0] src_row_step;
      logic [AW-1:0] src_col_step;
      logic [AW-1:0] dst_row_step;
      logic [AW-1:0] dst_col_step;
   } run_type;

   typedef struct packed {
      logic                          kind;
      logic [rrca_pkg::STATUS_W-1:0] status;
      logic [AW-1:0]                 src_addr;
      logic [AW-1:0]                 dst_addr;
      logic                          last;
      logic [CW-1:0]                 region_x;
      logic [CW-1:0]                 region_y;
      logic [DW-1:0]                 region_w;
      logic [DW-1:0]                 region_h;
   } rsp_type;

   logic    busy_ff, busy_in;
   logic    rsp_valid_ff, rsp_valid_in;
   run_type run_ff, run_in;
   rsp_type rsp_ff, rsp_in;

   logic          out_free, emits, fire, col_end, row_end, last_pair;
   logic [AW-1:0] src_next_base, dst_next_base;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   // a step while idle leaves the queue without a response
   assign emits     = head.is_start || busy_ff;
   assign pop       = !fifo_empty && (out_free || !emits);
   assign fire      = pop && emits;

   assign col_end   = ({1'b0, run_ff.col} + 1'b1) >= {1'b0, run_ff.run_w};
   assign row_end   = ({1'b0, run_ff.row} + 1'b1) >= {1'b0, run_ff.run_h};
   assign last_pair = col_end && row_end;

   assign src_next_base = run_ff.src_base + run_ff.src_row_step;
   assign dst_next_base = run_ff.dst_base + run_ff.dst_row_step;

   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_tready);

   always_comb begin
      busy_in = busy_ff;
      run_in  = run_ff;
      rsp_in  = rsp_ff;
      if (fire && head.is_start) begin
         rsp_in          = '0;
         rsp_in.kind     = rrca_pkg::KIND_ANSWER;
         rsp_in.status   = head.status;
         rsp_in.region_x = head.region_x;
         rsp_in.region_y = head.region_y;
         rsp_in.region_w = head.region_w;
         rsp_in.region_h = head.region_h;
         busy_in = (head.status == rrca_pkg::STATUS_OK) &&
                   (head.run_w != '0) && (head.run_h != '0);
         run_in.run_w        = head.run_w;
         run_in.run_h        = head.run_h;
         run_in.row          = '0;
         run_in.col          = '0;
         run_in.src_cur      = head.src_origin;
         run_in.src_base     = head.src_origin;
         run_in.dst_cur      = head.dst_origin;
         run_in.dst_base     = head.dst_origin;
         run_in.src_row_step = head.src_row_step;
         run_in.src_col_step = head.src_col_step;
         run_in.dst_row_step = head.dst_row_step;
         run_in.dst_col_step = head.dst_col_step;
      end else if (fire) begin
         rsp_in          = '0;
         rsp_in.kind     = rrca_pkg::KIND_PAIR;
         rsp_in.src_addr = run_ff.src_cur;
         rsp_in.dst_addr = run_ff.dst_cur;
         rsp_in.last     = last_pair;
         if (last_pair) begin
            busy_in = 1'b0;
         end else if (col_end) begin
            run_in.col      = '0;
            run_in.row      = run_ff.row + 1'b1;
            run_in.src_base = src_next_base;
            run_in.src_cur  = src_next_base;
            run_in.dst_base = dst_next_base;
            run_in.dst_cur  = dst_next_base;
         end else begin
            run_in.col     = run_ff.col + 1'b1;
            run_in.src_cur = run_ff.src_cur + run_ff.src_col_step;
            run_in.dst_cur = run_ff.dst_cur + run_ff.dst_col_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff <= run_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {4'b0, rsp_ff.region_h, rsp_ff.region_w, rsp_ff.region_y,
                        rsp_ff.region_x, rsp_ff.dst_addr, rsp_ff.src_addr, rsp_ff.status};

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (fire && !head.is_start && last_pair) |=> !busy_ff)
      else $error("run still busy after its last pair");

   a_counts_in_run: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (run_ff.col < run_ff.run_w && run_ff.row < run_ff.run_h))
      else $error("row or column counter outside the clipped rectangle");

   a_busy_from_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy_ff) |-> $past(fire && head.is_start))
      else $error("run started without a start transaction");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !fire)
      else $error("response overwritten while stalled");

endmodule

/* rtl/rotated_rect_copy_addresser.sv */
// An accepted request passes capture, clip, origin multiply into the 4-entry queue and the
// response register before its response appears on rsp; a stall on rsp holds it back.
// Throughput: one transaction per cycle while rsp does not stall; each step yields one
// address pair, at one per cycle while rsp does not stall, from the address adders in the back end.
// Steps while no run is active and command code 3 are accepted and give no response.
// Reset (synchronous, active high) empties the pipeline and queue, ends any run and
// restores rotation 0 with all dimensions 2048.
module rotated_rect_copy_addresser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wen,
   input  logic [rrca_pkg::REG_IDX_W-1:0]      csr_index,
   input  logic [rrca_pkg::DIM_W-1:0]          csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // rect_x, rect_y, rect_w, rect_h, dest_x, dest_y, zero fill
   input  logic [rrca_pkg::REQ_DATA_W-1:0]     req_tdata,
   // cmd
   input  logic [rrca_pkg::CMD_W-1:0]          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // status, src_addr, dst_addr, region_x, region_y, region_w, region_h, zero fill
   output logic [rrca_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // kind
   output logic [0:0]                          rsp_tuser,
   output logic                                rsp_tlast
);

   rrca_pkg::cfg_type   cfg_ff, cfg_in;
   rrca_pkg::entry_type push_entry, head;
   logic                push, pop, fifo_empty, fifo_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            rrca_pkg::REG_ROTATION:      cfg_in.rotation      = csr_wdata[rrca_pkg::ROT_W-1:0];
            rrca_pkg::REG_BITMAP_WIDTH:  cfg_in.bitmap_width  = csr_wdata;
            rrca_pkg::REG_BITMAP_HEIGHT: cfg_in.bitmap_height = csr_wdata;
            rrca_pkg::REG_SCREEN_WIDTH:  cfg_in.screen_width  = csr_wdata;
            rrca_pkg::REG_SCREEN_HEIGHT: cfg_in.screen_height = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rotation      <= rrca_pkg::ROT_NONE;
         cfg_ff.bitmap_width  <= rrca_pkg::DIM_W'(rrca_pkg::MAX_DIM);
         cfg_ff.bitmap_height <= rrca_pkg::DIM_W'(rrca_pkg::MAX_DIM);
         cfg_ff.screen_width  <= rrca_pkg::DIM_W'(rrca_pkg::MAX_DIM);
         cfg_ff.screen_height <= rrca_pkg::DIM_W'(rrca_pkg::MAX_DIM);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rrca_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .fifo_full  (fifo_full),
      .push       (push),
      .push_entry (push_entry)
   );

   rrca_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (fifo_empty),
      .full       (fifo_full)
   );

   rrca_back u_back (
      .clock      (clock),
      .reset      (reset),
      .fifo_empty (fifo_empty),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* verif/rrca_checker.sv */
module rrca_checker
   import rrca_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wen,
   input  logic [REG_IDX_W-1:0]  csr_index,
   input  logic [DIM_W-1:0]      csr_wdata,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [CMD_W-1:0]      req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic [0:0]            rsp_tuser,
   input  logic                  rsp_tlast,
   output int                    fail_count,
   output int                    due_count,
   output int                    accepted_count
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic                kind;
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   src_addr;
      logic [ADDR_W-1:0]   dst_addr;
      logic                is_last;
      logic [COORD_W-1:0]  region_x;
      logic [COORD_W-1:0]  region_y;
      logic [DIM_W-1:0]    region_w;
      logic [DIM_W-1:0]    region_h;
   } blit_out_type;

   blit_out_type blit_results_due[$];

   // register copies
   logic [ROT_W-1:0] rotation;
   logic [DIM_W-1:0] bitmap_w, bitmap_h, screen_w, screen_h;

   // run state, latched at start
   logic        running;
   int unsigned row, col, run_w, run_h;
   int unsigned src_base, dst_base, src_row_inc, src_col_inc, dst_row_inc, dst_col_inc;

   int errors;
   int taken;

   function automatic int unsigned sat_dim(input int unsigned v);
      return (v > MAX_DIM) ? MAX_DIM : v;
   endfunction

   function automatic int unsigned lesser(input int unsigned a, input int unsigned b);
      return (a < b) ? a : b;
   endfunction

   task automatic clip_start(input logic snap, input logic [REQ_DATA_W-1:0] d,
                             output blit_out_type res);
      int unsigned bw, bh, sw, sh, rx, ry, rw, rh, dx, dy;
      int unsigned w, h, gx, gy, gw, gh, xo, yo;
      bw = sat_dim(bitmap_w);
      bh = sat_dim(bitmap_h);
      sw = sat_dim(screen_w);
      sh = sat_dim(screen_h);
      rx = d[10:0];
      ry = d[21:11];
      rw = d[33:22];
      rh = d[45:34];
      dx = d[56:46];
      dy = d[67:57];
      res = '{kind: KIND_ANSWER, status: STATUS_OK, default: '0};
      running = 1'b0;
      if (rotation != ROT_90 && rotation != ROT_180) begin
         res.status = STATUS_ROTATION;
         return;
      end
      if (!snap) begin
         if (rx >= bw || ry >= bh) begin
            res.status = STATUS_RANGE;
            return;
         end
         src_base    = ry * bw + rx;
         src_row_inc = bw;
         src_col_inc = 1;
         if (rotation == ROT_180) begin
            if (dx >= sw || dy >= sh) begin
               res.status = STATUS_RANGE;
               return;
            end
            xo = sw - dx;
            yo = sh - dy;
            w  = lesser(lesser(rw, xo), bw - rx);
            h  = lesser(lesser(rh, yo), bh - ry);
            dst_base    = (yo - 1) * sw + xo - 1;
            dst_row_inc = 0 - sw;
            dst_col_inc = 0 - 1;
            gx = xo - w;
            gy = yo - h;
            gw = w;
            gh = h;
         end else begin
            if (dx >= sh || dy >= sw) begin
               res.status = STATUS_RANGE;
               return;
            end
            w = lesser(lesser(rw, bw - rx), sh - dx);
            h = lesser(lesser(rh, bh - ry), sw - dy);
            dst_base    = dx * sw + sw - 1 - dy;
            dst_row_inc = 0 - 1;
            dst_col_inc = sw;
            gx = sw - h - dy;
            gy = dx;
            gw = h;
            gh = w;
         end
      end else begin
         // snap fills the bitmap from its origin and reads the shadow from a start set by the rotation and clipped size
         dst_base    = 0;
         dst_row_inc = bw;
         dst_col_inc = 1;
         if (rotation == ROT_180) begin
            if (rx >= sw || ry >= sh) begin
               res.status = STATUS_RANGE;
               return;
            end
            w = lesser(lesser(rw, bw), sw - rx);
            h = lesser(lesser(rh, bh), sh - ry);
            src_base    = (w != 0 && h != 0) ? (h - 1) * sw + w - 1 : 0;
            src_row_inc = 0 - sw;
            src_col_inc = 0 - 1;
            gx = sw - rx - w;
            gy = sh - ry - h;
            gw = w;
            gh = h;
         end else begin
            if (rx >= sh || ry >= sw) begin
               res.status = STATUS_RANGE;
               return;
            end
            w = lesser(lesser(rw, bw), sh - rx);
            h = lesser(lesser(rh, bh), sw - ry);
            src_base    = (h != 0) ? h - 1 : 0;
            src_row_inc = 0 - 1;
            src_col_inc = sw;
            gx = sw - ry - h;
            gy = rx;
            gw = h;
            gh = w;
         end
      end
      run_w   = w;
      run_h   = h;
      row     = 0;
      col     = 0;
      running = (w != 0 && h != 0);
      res.region_x = gx[COORD_W-1:0];
      res.region_y = gy[COORD_W-1:0];
      res.region_w = gw[DIM_W-1:0];
      res.region_h = gh[DIM_W-1:0];
   endtask

   task automatic next_pair(output blit_out_type res);
      int unsigned sa, da;
      logic        at_end;
      sa = src_base + row * src_row_inc + col * src_col_inc;
      da = dst_base + row * dst_row_inc + col * dst_col_inc;
      at_end = (row + 1 >= run_h) && (col + 1 >= run_w);
      res = '{kind: KIND_PAIR, status: STATUS_OK, default: '0};
      res.src_addr = sa[ADDR_W-1:0];
      res.dst_addr = da[ADDR_W-1:0];
      res.is_last  = at_end;
      if (at_end) begin
         running = 1'b0;
      end else if (col + 1 >= run_w) begin
         col = 0;
         row = (row + 1) & 32'hFFF;
      end else begin
         col = (col + 1) & 32'hFFF;
      end
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      blit_out_type want;
      if (reset) begin
         blit_results_due.delete();
         rotation = ROT_NONE;
         bitmap_w = DIM_W'(MAX_DIM);
         bitmap_h = DIM_W'(MAX_DIM);
         screen_w = DIM_W'(MAX_DIM);
         screen_h = DIM_W'(MAX_DIM);
         running  = 1'b0;
         row = 0; col = 0; run_w = 0; run_h = 0;
         src_base = 0; dst_base = 0;
         src_row_inc = 0; src_col_inc = 0; dst_row_inc = 0; dst_col_inc = 0;
         errors = 0;
         taken  = 0;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               REG_ROTATION:      rotation = csr_wdata[ROT_W-1:0];
               REG_BITMAP_WIDTH:  bitmap_w = csr_wdata;
               REG_BITMAP_HEIGHT: bitmap_h = csr_wdata;
               REG_SCREEN_WIDTH:  screen_w = csr_wdata;
               REG_SCREEN_HEIGHT: screen_h = csr_wdata;
               default: ;
            endcase
         end

         if (rsp_tvalid && rsp_tready) begin
            if (blit_results_due.size() == 0) begin
               $error("response transaction with nothing expected");
               errors++;
            end else begin
               want = blit_results_due.pop_front();
               check_field("kind", want.kind, rsp_tuser[0]);
               check_field("status", want.status, rsp_tdata[1:0]);
               check_field("src_addr", want.src_addr, rsp_tdata[23:2]);
               check_field("dst_addr", want.dst_addr, rsp_tdata[45:24]);
               check_field("last", want.is_last, rsp_tlast);
               check_field("region_x", want.region_x, rsp_tdata[56:46]);
               check_field("region_y", want.region_y, rsp_tdata[67:57]);
               check_field("region_w", want.region_w, rsp_tdata[79:68]);
               check_field("region_h", want.region_h, rsp_tdata[91:80]);
            end
         end

         if (req_tvalid && req_tready) begin
            taken++;
            if (req_tuser == CMD_UPDATE || req_tuser == CMD_SNAP) begin
               clip_start(req_tuser == CMD_SNAP, req_tdata, want);
               blit_results_due.push_back(want);
            end else if (req_tuser == CMD_STEP && running) begin
               next_pair(want);
               blit_results_due.push_back(want);
            end
         end
      end
      fail_count     <= errors;
      due_count      <= blit_results_due.size();
      accepted_count <= taken;
   end

endmodule

/* verif/tb_rotated_rect_copy_addresser.sv */
module tb_rotated_rect_copy_addresser;
   import rrca_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
   localparam int ITEM_TARGET  = 1900;
   localparam int PHASE_ITEMS  = 160;
   localparam int DRAIN_CYCLES = 8;
   localparam int CLIP_CAP     = 16;

   logic                  clock;
   logic                  reset;
   logic                  csr_wen;
   logic [REG_IDX_W-1:0]  csr_index;
   logic [DIM_W-1:0]      csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [CMD_W-1:0]      req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]            rsp_tuser;
   logic                  rsp_tlast;

   int fail_count, due_count, accepted_count;
   int req_gap_max = 9;
   int rsp_gap_max = 9;
   int rsp_hold = 0;

   int unsigned cur_rot, cur_bw, cur_bh, cur_sw, cur_sh;

   rotated_rect_copy_addresser u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   rrca_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_wen        (csr_wen),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .fail_count     (fail_count),
      .due_count      (due_count),
      .accepted_count (accepted_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // response side: after each transaction hold tready low for a random count
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         rsp_hold = $urandom_range(0, rsp_gap_max);
      end else if (rsp_hold > 0) begin
         rsp_hold = rsp_hold - 1;
      end
      rsp_tready <= (rsp_hold == 0);
   end

   initial begin
      #5ms;
      $display("[rotated_rect_copy_addresser] ERROR");
      $finish;
   end

   function automatic int unsigned lesser(input int unsigned a, input int unsigned b);
      return (a < b) ? a : b;
   endfunction

   task automatic issue(input logic [CMD_W-1:0] cmd, input int unsigned rx, input int unsigned ry,
                        input int unsigned rw, input int unsigned rh,
                        input int unsigned dx, input int unsigned dy);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'b0, dy[10:0], dx[10:0], rh[11:0], rw[11:0], ry[10:0], rx[10:0]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic issue_step();
      issue(CMD_STEP, $urandom_range(0, 2047), $urandom_range(0, 2047),
            $urandom_range(0, 2048), $urandom_range(0, 2048),
            $urandom_range(0, 2047), $urandom_range(0, 2047));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (due_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input int unsigned val);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[DIM_W-1:0];
      @(posedge clock);
   endtask

   task automatic program_regs(input int unsigned rot, input int unsigned bw,
                               input int unsigned bh, input int unsigned sw,
                               input int unsigned sh);
      set_reg(REG_ROTATION, rot);
      set_reg(REG_BITMAP_WIDTH, bw);
      set_reg(REG_BITMAP_HEIGHT, bh);
      set_reg(REG_SCREEN_WIDTH, sw);
      set_reg(REG_SCREEN_HEIGHT, sh);
      csr_wen <= 1'b0;
      cur_rot = rot;
      cur_bw  = bw;
      cur_bh  = bh;
      cur_sw  = sw;
      cur_sh  = sh;
   endtask

   function automatic int unsigned pick_dim();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return $urandom_range(1, 12);
      if (r < 8) return ($urandom_range(0, 1) != 0) ? MAX_DIM : 1;
      return $urandom_range(1, MAX_DIM);
   endfunction

   // mostly inside the legal range, often hugging its far edge so big sizes clip
   function automatic int unsigned pick_coord(input int unsigned lim);
      int r;
      r = $urandom_range(0, 9);
      if (r < 2) return $urandom_range(0, 2047);
      if (r < 5) return lim - 1 - $urandom_range(0, lesser(lim - 1, 7));
      return $urandom_range(0, lim - 1);
   endfunction

   function automatic int unsigned pick_size();
      int r;
      r = $urandom_range(0, 19);
      if (r < 14) return $urandom_range(0, 6);
      if (r < 16) return MAX_DIM;
      if (r < 18) return $urandom_range(7, 16);
      return $urandom_range(0, MAX_DIM);
   endfunction

   function automatic logic [CMD_W-1:0] pick_cmd();
      case ($urandom_range(0, 3))
         0:       return CMD_UPDATE;
         1:       return CMD_SNAP;
         2:       return CMD_STEP;
         default: return CMD_NONE;
      endcase
   endfunction

   task automatic run_sequence();
      logic        snap, rot_half;
      int unsigned rx, ry, rw, rh, dx, dy, nsteps;
      if ($urandom_range(0, 9) == 0) begin
         // noise: any command, any fields
         issue(pick_cmd(), $urandom_range(0, 2047), $urandom_range(0, 2047),
               $urandom_range(0, 2048), $urandom_range(0, 2048),
               $urandom_range(0, 2047), $urandom_range(0, 2047));
         return;
      end
      snap     = ($urandom_range(0, 2) == 0);
      rot_half = (cur_rot == ROT_180);
      if (snap) begin
         rx = pick_coord(rot_half ? cur_sw : cur_sh);
         ry = pick_coord(rot_half ? cur_sh : cur_sw);
         dx = $urandom_range(0, 2047);
         dy = $urandom_range(0, 2047);
      end else begin
         rx = pick_coord(cur_bw);
         ry = pick_coord(cur_bh);
         dx = pick_coord(rot_half ? cur_sw : cur_sh);
         dy = pick_coord(rot_half ? cur_sh : cur_sw);
      end
      rw = pick_size();
      rh = pick_size();
      issue(snap ? CMD_SNAP : CMD_UPDATE, rx, ry, rw, rh, dx, dy);
      if ($urandom_range(0, 6) == 0) begin
         nsteps = $urandom_range(0, 3);
      end else begin
         nsteps = lesser(lesser(rw, CLIP_CAP) * lesser(rh, CLIP_CAP), 48)
                  + $urandom_range(0, 2);
      end
      repeat (nsteps) issue_step();
   endtask

   initial begin
      int r, phase_end;
      reset      <= 1'b1;
      csr_wen    <= 1'b0;
      csr_index  <= REG_ROTATION;
      csr_wdata  <= '0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= CMD_UPDATE;
      cur_rot = ROT_NONE;
      cur_bw  = MAX_DIM;
      cur_bh  = MAX_DIM;
      cur_sw  = MAX_DIM;
      cur_sh  = MAX_DIM;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset rotation is unsupported
      issue(CMD_UPDATE, 0, 0, 1, 1, 0, 0);
      issue(CMD_SNAP, 0, 0, 1, 1, 0, 0);
      wait_drained();

      program_regs(ROT_90, 5, 4, 6, 7);
      issue(CMD_UPDATE, 3, 2, MAX_DIM, MAX_DIM, 5, 4);
      repeat (5) issue_step();                         // last one lands on an idle block
      issue(CMD_UPDATE, 2047, 0, 1, 1, 0, 0);          // corner off the bitmap
      issue(CMD_UPDATE, 0, 0, 1, 1, 2047, 2047);       // offset off the screen
      issue(CMD_UPDATE, 0, 0, 0, 5, 0, 0);             // empty rectangle
      issue_step();
      issue(CMD_SNAP, 1, 1, 3, 3, 0, 0);
      repeat (2) issue_step();
      issue(CMD_UPDATE, 4, 3, 1, 2, 0, 0);             // restart mid-run
      issue_step();
      issue(CMD_NONE, 0, 0, 0, 0, 0, 0);
      wait_drained();

      program_regs(ROT_180, MAX_DIM, MAX_DIM, MAX_DIM, MAX_DIM);
      issue(CMD_UPDATE, 2047, 2047, MAX_DIM, MAX_DIM, 0, 0);
      issue_step();
      issue(CMD_SNAP, 2046, 2046, MAX_DIM, MAX_DIM, 2047, 2047);
      repeat (4) issue_step();
      wait_drained();

      // smallest geometry everywhere first, then random settings
      program_regs(ROT_90, 1, 1, 1, 1);
      while (accepted_count < ITEM_TARGET) begin
         phase_end = accepted_count + PHASE_ITEMS;
         while (accepted_count < phase_end && accepted_count < ITEM_TARGET) begin
            run_sequence();
         end
         wait_drained();
         req_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
         rsp_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
         r = $urandom_range(0, 9);
         program_regs((r == 0) ? ROT_NONE : (r == 1) ? ROT_270 : (r < 6) ? ROT_90 : ROT_180,
                      pick_dim(), pick_dim(), pick_dim(), pick_dim());
      end

      wait_drained();
      if (fail_count == 0) begin
         $display("[rotated_rect_copy_addresser] OK");
      end else begin
         $display("[rotated_rect_copy_addresser] ERROR");
      end
      $finish;
   end

endmodule
